/* hdl/vmt_pkg.sv */
// Shared types, register offsets and constants of the virtio MMIO transport.
// No dependencies; every module file imports this package.
`timescale 1ns / 1ps

package vmt_pkg;

    // Operation codes of one input word
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_IRQ   = 2'd2
    } t_op;

    // Register offsets, published virtio-mmio layout
    localparam logic [11:0] OFS_MAGIC        = 12'h000;
    localparam logic [11:0] OFS_VERSION      = 12'h004;
    localparam logic [11:0] OFS_DEVICE_ID    = 12'h008;
    localparam logic [11:0] OFS_VENDOR       = 12'h00C;
    localparam logic [11:0] OFS_DEV_FEAT     = 12'h010;
    localparam logic [11:0] OFS_DEV_FEAT_SEL = 12'h014;
    localparam logic [11:0] OFS_QUEUE_SEL    = 12'h030;
    localparam logic [11:0] OFS_QUEUE_MAX    = 12'h034;
    localparam logic [11:0] OFS_QUEUE_NUM    = 12'h038;
    localparam logic [11:0] OFS_QUEUE_READY  = 12'h044;
    localparam logic [11:0] OFS_QUEUE_NOTIFY = 12'h050;
    localparam logic [11:0] OFS_IRQ_STATUS   = 12'h060;
    localparam logic [11:0] OFS_IRQ_ACK      = 12'h064;
    localparam logic [11:0] OFS_STATUS       = 12'h070;
    localparam logic [11:0] OFS_DESC_LO      = 12'h080;
    localparam logic [11:0] OFS_DESC_HI      = 12'h084;
    localparam logic [11:0] OFS_AVAIL_LO     = 12'h090;
    localparam logic [11:0] OFS_AVAIL_HI     = 12'h094;
    localparam logic [11:0] OFS_USED_LO      = 12'h0A0;
    localparam logic [11:0] OFS_USED_HI      = 12'h0A4;

    // Read-only constant values
    localparam logic [31:0] MAGIC_VALUE   = 32'h7472_6976;
    localparam logic [31:0] VENDOR_VALUE  = 32'h554D_4551;
    localparam logic [31:0] VERSION_VALUE = 32'd2;
    localparam logic [31:0] QUEUE_MAX     = 32'd128;

    localparam int DEVICE_ID_W = 8;

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] offset;
        logic [31:0] write_data;
    } t_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic        notify_pulse;
        logic        irq_raise;
        logic        queue_ready_out;
        logic [15:0] queue_size_out;
        logic [63:0] desc_table_addr;
        logic [63:0] avail_ring_addr;
        logic [63:0] used_ring_addr;
    } t_result;

endpackage

/* hdl/vmt_if.sv */
// Request and response channel interfaces of the virtio MMIO transport.
// Depends on nothing; payload widths follow vmt_pkg field widths.
`timescale 1ns / 1ps

interface vmt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [11:0] offset;
    logic [31:0] write_data;

    modport source (output valid, output op, output offset, output write_data, input ready);
    modport sink   (input valid, input op, input offset, input write_data, output ready);
endinterface

interface vmt_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        notify_pulse;
    logic        irq_raise;
    logic        queue_ready_out;
    logic [15:0] queue_size_out;
    logic [63:0] desc_table_addr;
    logic [63:0] avail_ring_addr;
    logic [63:0] used_ring_addr;

    modport source (
        output valid, output read_data, output notify_pulse, output irq_raise,
        output queue_ready_out, output queue_size_out, output desc_table_addr,
        output avail_ring_addr, output used_ring_addr, input ready
    );
    modport sink (
        input valid, input read_data, input notify_pulse, input irq_raise,
        input queue_ready_out, input queue_size_out, input desc_table_addr,
        input avail_ring_addr, input used_ring_addr, output ready
    );
endinterface

/* hdl/vmt_in_stage.sv */
// Input register of the transport: holds one request word until it advances.
// Depends on vmt_pkg.
`timescale 1ns / 1ps

module vmt_in_stage
    import vmt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  logic  i_advance,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    // take a new word when empty or when the held word leaves this cycle
    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

/* hdl/vmt_core.sv */
// Transport register state, read mux and write decode for one request word.
// Depends on vmt_pkg.
`timescale 1ns / 1ps

module vmt_core
    import vmt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [DEVICE_ID_W-1:0] i_cfg_data,
    input  logic                   i_fire,
    input  t_item                  i_item,
    output t_result                o_result
);

    logic [DEVICE_ID_W-1:0] r_device_id;
    logic [31:0] r_feat_sel,    n_feat_sel;
    logic [31:0] r_queue_sel,   n_queue_sel;
    logic [15:0] r_queue_size,  n_queue_size;
    logic        r_queue_ready, n_queue_ready;
    logic [63:0] r_desc_base,   n_desc_base;
    logic [63:0] r_avail_base,  n_avail_base;
    logic [63:0] r_used_base,   n_used_base;
    logic        r_irq_status,  n_irq_status;
    logic [31:0] r_dev_status,  n_dev_status;

    logic [31:0] rd_data;
    logic        notify;
    logic        irq;
    logic [31:0] wd;

    assign wd = i_item.write_data;

    always_comb begin
        rd_data = '0;
        unique case (i_item.offset)
            OFS_MAGIC:       rd_data = MAGIC_VALUE;
            OFS_VERSION:     rd_data = VERSION_VALUE;
            OFS_DEVICE_ID:   rd_data = {{(32-DEVICE_ID_W){1'b0}}, r_device_id};
            OFS_VENDOR:      rd_data = VENDOR_VALUE;
            OFS_DEV_FEAT:    rd_data = {31'd0, (r_feat_sel == 32'd1)};
            OFS_QUEUE_MAX:   rd_data = QUEUE_MAX;
            OFS_QUEUE_READY: rd_data = {31'd0, r_queue_ready};
            OFS_IRQ_STATUS:  rd_data = {31'd0, r_irq_status};
            OFS_STATUS:      rd_data = r_dev_status;
            default:         rd_data = '0;
        endcase
    end

    always_comb begin
        n_feat_sel    = r_feat_sel;
        n_queue_sel   = r_queue_sel;
        n_queue_size  = r_queue_size;
        n_queue_ready = r_queue_ready;
        n_desc_base   = r_desc_base;
        n_avail_base  = r_avail_base;
        n_used_base   = r_used_base;
        n_irq_status  = r_irq_status;
        n_dev_status  = r_dev_status;
        notify        = 1'b0;
        irq           = 1'b0;
        unique case (t_op'(i_item.op))
            OP_WRITE: begin
                unique case (i_item.offset)
                    OFS_DEV_FEAT_SEL: n_feat_sel = wd;
                    OFS_QUEUE_SEL:    n_queue_sel = wd;
                    OFS_QUEUE_NUM: begin
                        if (r_queue_sel == 32'd0) begin
                            n_queue_size = wd[15:0];
                        end
                    end
                    OFS_QUEUE_READY: begin
                        if (r_queue_sel == 32'd0) begin
                            n_queue_ready = (wd != 32'd0);
                        end
                    end
                    OFS_QUEUE_NOTIFY: notify = (wd == 32'd0);
                    OFS_IRQ_ACK:      n_irq_status = r_irq_status & ~wd[0];
                    OFS_STATUS: begin
                        n_dev_status = wd;
                        // device reset: drop queue size, ready flag, ring addresses and the interrupt
                        if (wd == 32'd0) begin
                            n_queue_size  = '0;
                            n_queue_ready = 1'b0;
                            n_desc_base   = '0;
                            n_avail_base  = '0;
                            n_used_base   = '0;
                            n_irq_status  = 1'b0;
                        end
                    end
                    OFS_DESC_LO:  n_desc_base  = {r_desc_base[63:32], wd};
                    OFS_DESC_HI:  n_desc_base  = {wd, r_desc_base[31:0]};
                    OFS_AVAIL_LO: n_avail_base = {r_avail_base[63:32], wd};
                    OFS_AVAIL_HI: n_avail_base = {wd, r_avail_base[31:0]};
                    OFS_USED_LO:  n_used_base  = {r_used_base[63:32], wd};
                    OFS_USED_HI:  n_used_base  = {wd, r_used_base[31:0]};
                    default: ;
                endcase
            end
            OP_IRQ: begin
                n_irq_status = 1'b1;
                irq          = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_result.read_data       = (t_op'(i_item.op) == OP_READ) ? rd_data : 32'd0;
        o_result.notify_pulse    = notify;
        o_result.irq_raise       = irq;
        o_result.queue_ready_out = n_queue_ready;
        o_result.queue_size_out  = n_queue_size;
        o_result.desc_table_addr = n_desc_base;
        o_result.avail_ring_addr = n_avail_base;
        o_result.used_ring_addr  = n_used_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_id <= '0;
        end else if (i_cfg_we) begin
            r_device_id <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feat_sel    <= '0;
            r_queue_sel   <= '0;
            r_queue_size  <= '0;
            r_queue_ready <= 1'b0;
            r_desc_base   <= '0;
            r_avail_base  <= '0;
            r_used_base   <= '0;
            r_irq_status  <= 1'b0;
            r_dev_status  <= '0;
        end else if (i_fire) begin
            r_feat_sel    <= n_feat_sel;
            r_queue_sel   <= n_queue_sel;
            r_queue_size  <= n_queue_size;
            r_queue_ready <= n_queue_ready;
            r_desc_base   <= n_desc_base;
            r_avail_base  <= n_avail_base;
            r_used_base   <= n_used_base;
            r_irq_status  <= n_irq_status;
            r_dev_status  <= n_dev_status;
        end
    end

`ifndef SYNTHESIS
    a_irq_sets_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.op == OP_IRQ |=> r_irq_status)
        else $error("interrupt event did not set irq status");

    a_idle_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_queue_size) && $stable(r_desc_base) && $stable(r_irq_status))
        else $error("queue state changed without a request");

    a_read_only_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.op != OP_READ |-> o_result.read_data == 32'd0)
        else $error("read data driven for a non-read request");

    a_status_zero_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.op == OP_WRITE && i_item.offset == OFS_STATUS
            && i_item.write_data == 32'd0
        |=> r_queue_size == 16'd0 && !r_queue_ready && r_used_base == 64'd0 && !r_irq_status)
        else $error("device reset left queue state behind");
`endif

endmodule

/* hdl/vmt_out_stage.sv */
// Result register of the transport: holds one response word for the sink.
// Depends on vmt_pkg and vmt_rsp_if.
`timescale 1ns / 1ps

module vmt_out_stage
    import vmt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_result   i_result,
    vmt_rsp_if.source o_rsp
);

    logic    r_valid;
    t_result r_result;

    // load when empty or when the held word is taken this cycle
    assign o_ready = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_rsp.valid           = r_valid;
    assign o_rsp.read_data       = r_result.read_data;
    assign o_rsp.notify_pulse    = r_result.notify_pulse;
    assign o_rsp.irq_raise       = r_result.irq_raise;
    assign o_rsp.queue_ready_out = r_result.queue_ready_out;
    assign o_rsp.queue_size_out  = r_result.queue_size_out;
    assign o_rsp.desc_table_addr = r_result.desc_table_addr;
    assign o_rsp.avail_ring_addr = r_result.avail_ring_addr;
    assign o_rsp.used_ring_addr  = r_result.used_ring_addr;

endmodule

/* hdl/virtio_mmio_transport_registers.sv */
// Top level of the single-queue virtio MMIO (version 2) register file.
// Depends on vmt_pkg, vmt_if, vmt_in_stage, vmt_core and vmt_out_stage.
`timescale 1ns / 1ps

// Usage:
//   i_req carries one word per access: op (read, write, raise used-buffer
//   interrupt), the 12-bit register offset and the 32-bit write data.
//   o_rsp returns exactly one word per request: read data (zero unless a
//   read), the notify and interrupt pulses, and the queue ready flag, queue
//   size and the three ring addresses as they stand after the request.
//   i_cfg_we / i_cfg_data load the 8-bit device id; write it only while no
//   request is in flight.
// Timing:
//   A request is held in the input register, updates the register state as it
//   moves into the result register, and is offered on o_rsp from the result
//   register. One request is taken every cycle while o_rsp.ready is high; the
//   rate is set by the single state update per cycle in the core.
// Reset:
//   Synchronous, active low. Clears all transport registers, the device id
//   and both stage valid flags; no words are held afterwards.
// Backpressure:
//   When o_rsp.ready is low the result register holds its word, the input
//   register holds its word, and i_req.ready drops once both are full.

module virtio_mmio_transport_registers
    import vmt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [DEVICE_ID_W-1:0] i_cfg_data,
    vmt_req_if.sink                i_req,
    vmt_rsp_if.source              o_rsp
);

    t_item   req_item;
    t_item   held_item;
    logic    held_valid;
    logic    out_ready;
    logic    advance;
    t_result result;

    assign req_item.op         = i_req.op;
    assign req_item.offset     = i_req.offset;
    assign req_item.write_data = i_req.write_data;

    // advance a held request into the result register when there is room
    assign advance = held_valid && out_ready;

    vmt_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_req.valid),
        .o_ready   (i_req.ready),
        .i_item    (req_item),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    // state commits only when the request actually moves on
    vmt_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_fire     (advance),
        .i_item     (held_item),
        .o_result   (result)
    );

    vmt_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (held_valid),
        .o_ready  (out_ready),
        .i_result (result),
        .o_rsp    (o_rsp)
    );

endmodule
